[rtl/tiger_hash_engine_top_defines.svh]
// Assertion macros for the Tiger hash engine.
// Used by thash_compress and tiger_hash_engine_top; expects clk and rst_n in scope.
`ifndef TIGER_HASH_ENGINE_TOP_DEFINES_SVH
`define TIGER_HASH_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset
`define TH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset
`define TH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TH_ASSERT_IMPL(lbl, ante, cons, msg)
`define TH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/thash_pkg.sv]
// Shared types, constants and helpers for the Tiger hash engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package thash_pkg;

    localparam int SBOX_DEPTH     = 1024;
    localparam int SBOX_AW        = 10;
    localparam int CFG_DATA_W     = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int PASS_W         = 5;
    localparam int DEF_MAX_PASSES = 16;
    localparam int KEY_SHL        = 19;
    localparam int KEY_SHR        = 23;

    localparam logic [63:0] IV_A        = 64'h0123456789ABCDEF;
    localparam logic [63:0] IV_B        = 64'hFEDCBA9876543210;
    localparam logic [63:0] IV_C        = 64'hF096A5B4C3B2E187;
    localparam logic [63:0] KEY_CONST_A = 64'hA5A5A5A5A5A5A5A5;
    localparam logic [63:0] KEY_CONST_B = 64'h0123456789ABCDEF;
    localparam logic [7:0]  PAD_TIGER   = 8'h01;
    localparam logic [7:0]  PAD_TIGER2  = 8'h80;

    // Generator seed block, little-endian words
    localparam logic [7:0][63:0] SEED_WORDS = {
        64'h6D6168694220696C, 64'h4520646E61206E6F,
        64'h737265646E412073, 64'h736F52207962202C,
        64'h6E6F6974636E7546, 64'h2068736148207765,
        64'h4E20747361462041, 64'h202D207265676954
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PASS_COUNT = 2'd0,
        CFG_TIGER2     = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } out_word_t;

    typedef struct packed {
        logic              start;
        logic [PASS_W-1:0] passes;
        logic              seed_load;
        logic              restart;
        logic              byte_we;
        logic [5:0]        byte_pos;
        logic [7:0]        byte_val;
    } cmp_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cmp_stat_t;

    function automatic logic [7:0] lane_byte(input logic [63:0] w, input logic [2:0] k);
        return w[8*k +: 8];
    endfunction

endpackage
`default_nettype wire

[rtl/thash_sbox_ram.sv]
// S-box memory: 1024 x 64, one write port, two registered read ports.
// Depends on thash_pkg.
`timescale 1ns / 1ps
`default_nettype none
module thash_sbox_ram
    import thash_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [SBOX_AW-1:0] waddr,
    input  wire logic [63:0]        wdata,
    input  wire logic               rd_en,
    input  wire logic [SBOX_AW-1:0] addr_a,
    input  wire logic [SBOX_AW-1:0] addr_b,
    output logic      [63:0]        qa,
    output logic      [63:0]        qb
);

    logic [63:0] mem [SBOX_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports, data held between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            qa <= mem[addr_a];
            qb <= mem[addr_b];
        end
    end

endmodule
`default_nettype wire

[rtl/thash_compress.sv]
// Compression engine: block words, chaining words and round sequencer.
// Depends on thash_pkg; reads s-box words from thash_sbox_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "tiger_hash_engine_top_defines.svh"
module thash_compress
    import thash_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmp_ctrl_t          ctl,
    input  wire logic [63:0]        ram_qa,
    input  wire logic [63:0]        ram_qb,
    output logic                    rd_en,
    output logic      [SBOX_AW-1:0] rd_addr_a,
    output logic      [SBOX_AW-1:0] rd_addr_b,
    output logic      [2:0][63:0]   chain,
    output cmp_stat_t               stat
);

    typedef enum logic [3:0] {
        C_IDLE  = 4'b0001,
        C_ROUND = 4'b0010,
        C_KEY   = 4'b0100,
        C_FIN   = 4'b1000
    } cstate_t;

    cstate_t           cstate_reg, cstate_next;
    logic [2:0]        phase_reg, phase_next;
    logic [2:0]        round_reg, round_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [PASS_W-1:0] passes_reg, passes_next;
    logic [3:0]        step_reg, step_next;
    logic              rdv_reg, rdv_next;
    logic [2:0][63:0]  st_reg, st_next;
    logic [2:0][63:0]  r_reg, r_next;
    logic [7:0][63:0]  x_reg, x_next;
    logic [63:0]       v_reg, v_next;
    logic [63:0]       acca_reg, acca_next;
    logic [63:0]       accb_reg, accb_next;

    logic [1:0]  j;
    logic [63:0] vnew;
    logic [63:0] bm;
    logic [63:0] keyval;
    logic [63:0] kcur, kp1, kp2;

    // Lookup pair select for phases one to four
    assign j         = 2'(phase_reg - 3'd1);
    assign rd_addr_a = {j, lane_byte(v_reg, {j, 1'b0})};
    assign rd_addr_b = {~j, lane_byte(v_reg, {j, 1'b1})};
    assign vnew      = r_reg[2] ^ x_reg[0];
    assign chain     = st_reg;
    assign stat.busy = (cstate_reg != C_IDLE);

    // Multiply the b role word by 5, 7 or 9
    always_comb
    begin
        if (pass_reg == '0)
        begin
            bm = r_reg[1] + (r_reg[1] << 2);
        end
        else if (pass_reg == PASS_W'(1))
        begin
            bm = (r_reg[1] << 3) - r_reg[1];
        end
        else
        begin
            bm = r_reg[1] + (r_reg[1] << 3);
        end
    end

    // One key schedule step on the rotating word file
    always_comb
    begin
        kcur = x_reg[0];
        kp1  = x_reg[7];
        kp2  = x_reg[6];
        case (step_reg)
            4'd0:                            keyval = kcur - (kp1 ^ KEY_CONST_A);
            4'd3, 4'd9:                      keyval = kcur - (kp1 ^ ((~kp2) << KEY_SHL));
            4'd6, 4'd12:                     keyval = kcur - (kp1 ^ ((~kp2) >> KEY_SHR));
            4'd15:                           keyval = kcur - (kp1 ^ KEY_CONST_B);
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:  keyval = kcur ^ kp1;
            default:                         keyval = kcur + kp1;
        endcase
    end

    // Sequencer and datapath next state
    always_comb
    begin
        cstate_next = cstate_reg;
        phase_next  = phase_reg;
        round_next  = round_reg;
        pass_next   = pass_reg;
        passes_next = passes_reg;
        step_next   = step_reg;
        rdv_next    = 1'b0;
        st_next     = st_reg;
        r_next      = r_reg;
        x_next      = x_reg;
        v_next      = v_reg;
        acca_next   = acca_reg;
        accb_next   = accb_reg;
        rd_en       = 1'b0;
        stat.done   = 1'b0;

        // Fold in returning s-box words
        if (rdv_reg)
        begin
            acca_next = acca_reg ^ ram_qa;
            accb_next = accb_reg ^ ram_qb;
        end

        case (cstate_reg)
            C_IDLE:
            begin
                if (ctl.start)
                begin
                    r_next      = st_reg;
                    passes_next = ctl.passes;
                    phase_next  = '0;
                    round_next  = '0;
                    pass_next   = '0;
                    cstate_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                phase_next = phase_reg + 3'd1;
                case (phase_reg)
                    3'd0:
                    begin
                        v_next    = vnew;
                        r_next[2] = vnew;
                        acca_next = '0;
                        accb_next = '0;
                    end
                    3'd1, 3'd2, 3'd3, 3'd4:
                    begin
                        rd_en    = 1'b1;
                        rdv_next = 1'b1;
                    end
                    3'd6:
                    begin
                        r_next[0] = r_reg[0] - acca_reg;
                        r_next[1] = r_reg[1] + accb_reg;
                    end
                    3'd7:
                    begin
                        // Multiply, then rotate roles and block words
                        r_next[0] = bm;
                        r_next[1] = r_reg[2];
                        r_next[2] = r_reg[0];
                        for (int i = 0; i < 7; i++)
                        begin
                            x_next[i] = x_reg[i+1];
                        end
                        x_next[7]  = x_reg[0];
                        round_next = round_reg + 3'd1;
                        if (round_reg == 3'd7)
                        begin
                            if (pass_reg == passes_reg - PASS_W'(1))
                            begin
                                cstate_next = C_FIN;
                            end
                            else
                            begin
                                step_next   = '0;
                                cstate_next = C_KEY;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            C_KEY:
            begin
                for (int i = 0; i < 7; i++)
                begin
                    x_next[i] = x_reg[i+1];
                end
                x_next[7] = keyval;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    pass_next   = pass_reg + PASS_W'(1);
                    phase_next  = '0;
                    cstate_next = C_ROUND;
                end
            end
            C_FIN:
            begin
                st_next[0]  = r_reg[0] ^ st_reg[0];
                st_next[1]  = r_reg[1] - st_reg[1];
                st_next[2]  = r_reg[2] + st_reg[2];
                stat.done   = 1'b1;
                cstate_next = C_IDLE;
            end
            default:
            begin
                cstate_next = C_IDLE;
            end
        endcase

        // Loads from the controller are to be taken while idle; the block itself does not enforce it
        if (ctl.seed_load)
        begin
            x_next = SEED_WORDS;
        end
        if (ctl.byte_we)
        begin
            x_next[ctl.byte_pos[5:3]][8*ctl.byte_pos[2:0] +: 8] = ctl.byte_val;
        end
        if (ctl.restart)
        begin
            st_next = {IV_C, IV_B, IV_A};
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cstate_reg <= C_IDLE;
            phase_reg  <= '0;
            round_reg  <= '0;
            pass_reg   <= '0;
            passes_reg <= PASS_W'(3);
            step_reg   <= '0;
            rdv_reg    <= 1'b0;
            st_reg     <= {IV_C, IV_B, IV_A};
        end
        else
        begin
            cstate_reg <= cstate_next;
            phase_reg  <= phase_next;
            round_reg  <= round_next;
            pass_reg   <= pass_next;
            passes_reg <= passes_next;
            step_reg   <= step_next;
            rdv_reg    <= rdv_next;
            st_reg     <= st_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        x_reg    <= x_next;
        v_reg    <= v_next;
        acca_reg <= acca_next;
        accb_reg <= accb_next;
    end

    `TH_ASSERT_IMPL(a_start_when_idle, ctl.start, cstate_reg == C_IDLE, "start while busy")
    `TH_ASSERT_NEXT(a_fin_to_idle, cstate_reg == C_FIN, cstate_reg == C_IDLE, "fin not idle")
    `TH_ASSERT_NEXT(a_key_to_round, (cstate_reg == C_KEY) && (step_reg == 4'd15), (cstate_reg == C_ROUND) && (phase_reg == 3'd0), "key end lost")
    `TH_ASSERT_IMPL(a_read_in_round, rd_en, (cstate_reg == C_ROUND) && (phase_reg != 3'd0), "stray read")

endmodule
`default_nettype wire

[rtl/tiger_hash_engine_top.sv]
// Tiger / Tiger2 hash engine top: s-box build, byte intake, padding, digest out.
// Depends on thash_pkg, thash_sbox_ram and thash_compress.
//
//   channel  | signals                      | direction | word
//   in       | in_valid, in_ready, in_data  | input     | in_word_t (req_type, data_byte)
//   out      | out_valid, out_ready, out_data| output   | out_word_t (digest, index, last)
//   cfg      | cfg_we, cfg_index, cfg_data  | input     | pass_count, tiger2_padding
//
// A data byte is taken in idle and stored from the push state; the first byte of each block
// after the first adds one compression, run by the single s-box round loop and its two-port
// memory. A finish pushes 9 to 72 bytes, one per cycle while no compression runs, plus one or
// two compressions, then shows three words.
// After reset the s-box is built in the memory, with no word taken meanwhile.
// Stalls on out hold the block; config writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
`include "tiger_hash_engine_top_defines.svh"
module tiger_hash_engine_top
    import thash_pkg::*;
#(
    parameter int MAX_PASSES = DEF_MAX_PASSES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_word_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_word_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_GITER = 10'b0000000010,
        S_GCMP  = 10'b0000000100,
        S_GCOL  = 10'b0000001000,
        S_IDLE  = 10'b0000010000,
        S_PUSH  = 10'b0000100000,
        S_HCMP  = 10'b0001000000,
        S_FLUSH = 10'b0010000000,
        S_FWAIT = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        FP_PAD  = 2'd0,
        FP_ZERO = 2'd1,
        FP_LEN  = 2'd2
    } fphase_t;

    state_t               state_reg, state_next;
    fphase_t              fphase_reg, fphase_next;
    logic [SBOX_AW-1:0]   init_addr_reg, init_addr_next;
    logic [2:0]           rep_reg, rep_next;
    logic [7:0]           gi_reg, gi_next;
    logic [1:0]           grp_reg, grp_next;
    logic [2:0]           col_reg, col_next;
    logic [1:0]           gph_reg, gph_next;
    logic [1:0]           sel_reg, sel_next;
    logic [63:0]          byte_count_reg, byte_count_next;
    logic                 fin_reg, fin_next;
    logic [1:0]           oidx_reg, oidx_next;
    logic [PASS_W-1:0]    pass_cfg_reg;
    logic                 tiger2_reg;
    logic [63:0]          bits_reg, bits_next;
    logic [7:0]           data_reg, data_next;

    cmp_ctrl_t            ctl;
    cmp_stat_t            stat;
    logic [2:0][63:0]     chain;
    logic                 cmp_rd_en;
    logic [SBOX_AW-1:0]   cmp_addr_a, cmp_addr_b;
    logic                 ram_we, ram_rd_en;
    logic [SBOX_AW-1:0]   ram_waddr, ram_addr_a, ram_addr_b;
    logic [63:0]          ram_wdata, ram_qa, ram_qb;
    logic                 gen_rd;

    logic [5:0]           pos;
    logic                 need_cmp;
    logic [7:0]           push_val;
    logic                 do_write;
    logic [PASS_W-1:0]    live_passes;
    logic [63:0]          col_mask;
    logic [SBOX_AW-1:0]   p_addr, q_addr;

    thash_sbox_ram u_sbox (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .rd_en  (ram_rd_en),
        .addr_a (ram_addr_a),
        .addr_b (ram_addr_b),
        .qa     (ram_qa),
        .qb     (ram_qb)
    );

    thash_compress u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .ram_qa    (ram_qa),
        .ram_qb    (ram_qb),
        .rd_en     (cmp_rd_en),
        .rd_addr_a (cmp_addr_a),
        .rd_addr_b (cmp_addr_b),
        .chain     (chain),
        .stat      (stat)
    );

    // Clamp the pass count to three .. MAX_PASSES
    always_comb
    begin
        live_passes = pass_cfg_reg;
        if (live_passes < PASS_W'(3))
        begin
            live_passes = PASS_W'(3);
        end
        if ({{(32-PASS_W){1'b0}}, live_passes} > MAX_PASSES)
        begin
            live_passes = PASS_W'(MAX_PASSES);
        end
    end

    // Byte position and the value of the next pushed byte
    assign pos      = byte_count_reg[5:0];
    assign need_cmp = (byte_count_reg != '0) && (pos == 6'd0);
    always_comb
    begin
        if (!fin_reg)
        begin
            push_val = data_reg;
        end
        else
        begin
            case (fphase_reg)
                FP_PAD:  push_val = tiger2_reg ? PAD_TIGER2 : PAD_TIGER;
                FP_ZERO: push_val = 8'h00;
                default: push_val = lane_byte(bits_reg, pos[2:0]);
            endcase
        end
    end

    // S-box swap addresses
    assign col_mask = 64'hFF << {col_reg, 3'b000};
    assign p_addr   = {grp_reg, gi_reg};
    assign q_addr   = {grp_reg, lane_byte(chain[sel_reg], col_reg)};

    // Memory port select
    assign ram_rd_en  = gen_rd | cmp_rd_en;
    assign ram_addr_a = gen_rd ? p_addr : cmp_addr_a;
    assign ram_addr_b = gen_rd ? q_addr : cmp_addr_b;

    // Handshakes and result word
    assign in_ready             = (state_reg == S_IDLE);
    assign out_valid            = (state_reg == S_OUT);
    assign out_data.digest_word = chain[oidx_reg];
    assign out_data.word_index  = oidx_reg;
    assign out_data.last_word   = (oidx_reg == 2'd2);

    // Main sequencer
    always_comb
    begin
        state_next      = state_reg;
        fphase_next     = fphase_reg;
        init_addr_next  = init_addr_reg;
        rep_next        = rep_reg;
        gi_next         = gi_reg;
        grp_next        = grp_reg;
        col_next        = col_reg;
        gph_next        = gph_reg;
        sel_next        = sel_reg;
        byte_count_next = byte_count_reg;
        fin_next        = fin_reg;
        oidx_next       = oidx_reg;
        bits_next       = bits_reg;
        data_next       = data_reg;
        ctl             = '0;
        ctl.passes      = live_passes;
        ram_we          = 1'b0;
        ram_waddr       = p_addr;
        ram_wdata       = (ram_qa & ~col_mask) | (ram_qb & col_mask);
        gen_rd          = 1'b0;
        do_write        = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                // Identity fill: each byte of entry i is i mod 256
                ram_we         = 1'b1;
                ram_waddr      = init_addr_reg;
                ram_wdata      = {8{init_addr_reg[7:0]}};
                init_addr_next = init_addr_reg + 1'b1;
                if (init_addr_reg == SBOX_AW'(SBOX_DEPTH - 1))
                begin
                    state_next = S_GITER;
                end
            end
            S_GITER:
            begin
                gph_next = '0;
                col_next = '0;
                if (sel_reg == 2'd2)
                begin
                    sel_next      = '0;
                    ctl.seed_load = 1'b1;
                    ctl.start     = 1'b1;
                    ctl.passes    = PASS_W'(3);
                    state_next    = S_GCMP;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_GCOL;
                end
            end
            S_GCMP:
            begin
                if (stat.done)
                begin
                    state_next = S_GCOL;
                end
            end
            S_GCOL:
            begin
                case (gph_reg)
                    2'd0:
                    begin
                        gen_rd   = 1'b1;
                        gph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        ram_we   = 1'b1;
                        gph_next = 2'd2;
                    end
                    default:
                    begin
                        // Write the q entry and advance the byte column
                        ram_we    = 1'b1;
                        ram_waddr = q_addr;
                        ram_wdata = (ram_qb & ~col_mask) | (ram_qa & col_mask);
                        gph_next  = 2'd0;
                        col_next  = col_reg + 3'd1;
                        if (col_reg == 3'd7)
                        begin
                            grp_next = grp_reg + 2'd1;
                            if (grp_reg == 2'd3)
                            begin
                                gi_next = gi_reg + 8'd1;
                                if (gi_reg == 8'd255)
                                begin
                                    rep_next = rep_reg + 3'd1;
                                end
                            end
                            if ((rep_reg == 3'd4) && (gi_reg == 8'd255) && (grp_reg == 2'd3))
                            begin
                                ctl.restart = 1'b1;
                                state_next  = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_GITER;
                            end
                        end
                    end
                endcase
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    data_next   = in_data.data_byte;
                    fin_next    = in_data.req_type;
                    fphase_next = FP_PAD;
                    bits_next   = byte_count_reg << 3;
                    state_next  = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (need_cmp)
                begin
                    ctl.start  = 1'b1;
                    state_next = S_HCMP;
                end
                else
                begin
                    do_write = 1'b1;
                end
            end
            S_HCMP:
            begin
                if (stat.done)
                begin
                    do_write = 1'b1;
                end
            end
            S_FLUSH:
            begin
                ctl.start  = 1'b1;
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (stat.done)
                begin
                    oidx_next  = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    oidx_next = oidx_reg + 2'd1;
                    if (oidx_reg == 2'd2)
                    begin
                        ctl.restart     = 1'b1;
                        byte_count_next = '0;
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Store one byte, then pick the next padding step
        if (do_write)
        begin
            ctl.byte_we     = 1'b1;
            ctl.byte_pos    = pos;
            ctl.byte_val    = push_val;
            byte_count_next = byte_count_reg + 64'd1;
            if (!fin_reg)
            begin
                state_next = S_IDLE;
            end
            else if (fphase_reg == FP_LEN)
            begin
                state_next = (pos == 6'd63) ? S_FLUSH : S_PUSH;
            end
            else
            begin
                fphase_next = (pos == 6'd55) ? FP_LEN : FP_ZERO;
                state_next  = S_PUSH;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            fphase_reg     <= FP_PAD;
            init_addr_reg  <= '0;
            rep_reg        <= '0;
            gi_reg         <= '0;
            grp_reg        <= '0;
            col_reg        <= '0;
            gph_reg        <= '0;
            sel_reg        <= 2'd2;
            byte_count_reg <= '0;
            fin_reg        <= 1'b0;
            oidx_reg       <= '0;
            pass_cfg_reg   <= PASS_W'(3);
            tiger2_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fphase_reg     <= fphase_next;
            init_addr_reg  <= init_addr_next;
            rep_reg        <= rep_next;
            gi_reg         <= gi_next;
            grp_reg        <= grp_next;
            col_reg        <= col_next;
            gph_reg        <= gph_next;
            sel_reg        <= sel_next;
            byte_count_reg <= byte_count_next;
            fin_reg        <= fin_next;
            oidx_reg       <= oidx_next;
            // Config writes, unknown index dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PASS_COUNT: pass_cfg_reg <= cfg_data[PASS_W-1:0];
                    CFG_TIGER2:     tiger2_reg   <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        data_reg <= data_next;
    end

    `TH_ASSERT_IMPL(a_ready_not_out, in_ready, !out_valid, "ready while showing digest")
    `TH_ASSERT_IMPL(a_we_in_build, ram_we, (state_reg == S_INIT) || (state_reg == S_GCOL), "s-box write outside build")
    `TH_ASSERT_NEXT(a_last_to_idle, out_valid && out_ready && out_data.last_word, in_ready, "no restart after digest")
    `TH_ASSERT_IMPL(a_ready_engine_idle, in_ready, !stat.busy, "ready while compressing")

endmodule
`default_nettype wire
